### rtl/core/iepm_pkg.sv
// Package for the I2C EEPROM page master: channel item types, status codes
// and fixed protocol constants. Depends on nothing.
package iepm_pkg;

  // Paging and address width of the target EEPROM.
  localparam int unsigned PAGE_BYTES   = 32;
  localparam int unsigned ADDRESS_BITS = 16;
  localparam logic [15:0] ADDR_MASK    = 16'((32'd1 << ADDRESS_BITS) - 32'd1);

  // Control byte bases and the bit that leaves the shifter first.
  localparam logic [7:0] CTRL_WRITE = 8'b1010_0000;
  localparam logic [7:0] CTRL_READ  = 8'b1010_0001;
  localparam logic [7:0] MSB_BIT    = 8'h80;

  // Configuration register indexes.
  localparam logic [0:0] CFG_HALF_BIT = 1'd0;
  localparam logic [0:0] CFG_STRETCH  = 1'd1;

  // Completion status of a byte command.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_NACK    = 3'd3,
    ST_STOP    = 3'd4
  } iepm_status_t;

  // One input item: optional command plus the sampled line levels.
  typedef struct packed {
    logic        cmd_valid;
    logic        func;
    logic [2:0]  device_select;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        last_byte;
    logic        scl_in;
    logic        sda_in;
  } iepm_item_t;

  // One result item.
  typedef struct packed {
    logic        scl_pull_low;
    logic        sda_pull_low;
    logic        ready_res;
    logic        done_res;
    logic [7:0]  read_data;
    logic [2:0]  status;
  } iepm_result_t;

  // One configuration write.
  typedef struct packed {
    logic [0:0]  reg_index;
    logic [23:0] wdata;
  } iepm_cfg_t;

endpackage

### rtl/core/iepm_stream_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; the payload type is given where it is instantiated.
interface iepm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/i2c_eeprom_page_master_top.sv
// I2C EEPROM page master: per-tick bus sequencer with result register.
// Depends on iepm_pkg and iepm_stream_if.
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle while res is not stalled; a single pass of
// sequencer logic per tick sits between the state and result registers.
// Reset (rst, synchronous): sequencer idle, no burst open, lines released,
// half bit 5 ticks, stretch timeout 1000 ticks, no result pending.
module i2c_eeprom_page_master_top (
  input logic         clk,
  input logic         rst,
  iepm_stream_if.sink   cmd,
  iepm_stream_if.source res,
  iepm_stream_if.sink   cfg
);
  import iepm_pkg::*;

  // Sequencer phases.
  typedef enum logic [16:0] {
    PH_IDLE      = 17'h00001,
    PH_PRESTOP   = 17'h00002,
    PH_W_START   = 17'h00004,
    PH_W_CTRL    = 17'h00008,
    PH_W_AHI     = 17'h00010,
    PH_W_ALO     = 17'h00020,
    PH_W_DATA    = 17'h00040,
    PH_W_STOP    = 17'h00080,
    PH_R_START   = 17'h00100,
    PH_R_CTRLW   = 17'h00200,
    PH_R_AHI     = 17'h00400,
    PH_R_ALO     = 17'h00800,
    PH_R_RESTART = 17'h01000,
    PH_R_CTRLR   = 17'h02000,
    PH_R_BYTE    = 17'h04000,
    PH_R_STOP    = 17'h08000,
    PH_ERR_STOP  = 17'h10000
  } phase_t;

  // Outcome of one primitive evaluation.
  typedef enum logic [2:0] {
    RS_BUSY, RS_OK, RS_NACK, RS_TIMEOUT, RS_FAIL
  } rs_t;

  // Step codes within a primitive.
  localparam logic [2:0] PS_0    = 3'd0;
  localparam logic [2:0] PS_1    = 3'd1;
  localparam logic [2:0] PS_2    = 3'd2;
  localparam logic [2:0] PS_3    = 3'd3;
  localparam logic [2:0] PS_DONE = 3'd7;

  typedef struct packed {
    logic [2:0]  pstep;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic        sampled;
    logic        scl_drv;
    logic        sda_drv;
    logic [15:0] wait_cnt;
    logic [23:0] stretch_cnt;
  } seq_t;

  typedef struct packed {
    logic        func;
    logic [2:0]  dev;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
  } held_t;

  // Write one bit and poll SCL for clock stretching.
  function automatic rs_t bit_write(inout seq_t s, input logic v, input logic scl,
                                    input logic [15:0] av, input logic [23:0] tmo);
    rs_t r;
    r = RS_BUSY;
    case (s.pstep)
      PS_0: begin
        s.sda_drv = ~v; s.wait_cnt = av; s.pstep = PS_1;
      end
      PS_1: begin
        s.scl_drv = 1'b0; s.wait_cnt = av; s.stretch_cnt = '0; s.pstep = PS_2;
      end
      PS_2: begin
        if (scl) begin
          s.scl_drv = 1'b1; s.wait_cnt = av; s.pstep = PS_DONE;
        end else begin
          s.stretch_cnt = s.stretch_cnt + 24'd1;
          if (s.stretch_cnt >= tmo) r = RS_TIMEOUT;
        end
      end
      default: r = RS_OK;
    endcase
    return r;
  endfunction

  // Read one bit, sampling SDA after SCL has been seen high.
  function automatic rs_t bit_read(inout seq_t s, input logic scl, input logic sda,
                                   input logic [15:0] av, input logic [23:0] tmo);
    rs_t r;
    r = RS_BUSY;
    case (s.pstep)
      PS_0: begin
        s.sda_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_1;
      end
      PS_1: begin
        s.scl_drv = 1'b0; s.wait_cnt = '0; s.stretch_cnt = '0; s.pstep = PS_2;
      end
      PS_2: begin
        if (scl) begin
          s.wait_cnt = av; s.pstep = PS_3;
        end else begin
          s.stretch_cnt = s.stretch_cnt + 24'd1;
          if (s.stretch_cnt >= tmo) r = RS_TIMEOUT;
        end
      end
      PS_3: begin
        s.sampled = sda; s.scl_drv = 1'b1; s.wait_cnt = av; s.pstep = PS_DONE;
      end
      default: r = RS_OK;
    endcase
    return r;
  endfunction

  // One evaluation of the current phase; at most one completion and one action.
  function automatic rs_t run_step(inout seq_t s, input phase_t ph, input logic ack,
                                   input logic scl, input logic sda,
                                   input logic [15:0] av, input logic [23:0] tmo);
    rs_t r;
    r = RS_BUSY;
    case (ph) inside
      PH_W_START, PH_R_START, PH_R_RESTART: begin
        case (s.pstep)
          PS_0: begin s.sda_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_1; end
          PS_1: begin s.scl_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_2; end
          PS_2: begin
            if (!sda || !scl) r = RS_FAIL;
            else begin s.sda_drv = 1'b1; s.wait_cnt = av; s.pstep = PS_3; end
          end
          PS_3: begin s.scl_drv = 1'b1; s.wait_cnt = av; s.pstep = PS_DONE; end
          default: r = RS_OK;
        endcase
      end
      PH_PRESTOP, PH_W_STOP, PH_R_STOP, PH_ERR_STOP: begin
        case (s.pstep)
          PS_0: begin s.sda_drv = 1'b1; s.wait_cnt = av; s.pstep = PS_1; end
          PS_1: begin s.scl_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_2; end
          PS_2: begin s.sda_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_3; end
          PS_3: begin
            if (!sda) r = RS_FAIL;
            else begin s.wait_cnt = av; s.pstep = PS_DONE; end
          end
          default: r = RS_OK;
        endcase
      end
      PH_R_BYTE: begin
        if (s.bit_index == 4'd0) begin
          if (s.pstep == PS_0) begin
            s.sda_drv = 1'b0; s.wait_cnt = av; s.pstep = PS_DONE;
          end else begin
            s.bit_index = 4'd1; s.pstep = PS_0;
            r = bit_read(s, scl, sda, av, tmo);
          end
        end else if (s.bit_index <= 4'd8) begin
          r = bit_read(s, scl, sda, av, tmo);
          if (r == RS_OK) begin
            s.shift_byte = {s.shift_byte[6:0], s.sampled};
            s.bit_index = s.bit_index + 4'd1;
            s.pstep = PS_0;
            if (s.bit_index <= 4'd8) r = bit_read(s, scl, sda, av, tmo);
            else r = bit_write(s, ~ack, scl, av, tmo);
          end
        end else begin
          r = bit_write(s, ~ack, scl, av, tmo);
        end
      end
      default: begin
        if (s.bit_index < 4'd8) begin
          r = bit_write(s, (s.shift_byte & MSB_BIT) != 8'd0, scl, av, tmo);
          if (r == RS_OK) begin
            s.shift_byte = {s.shift_byte[6:0], 1'b0};
            s.bit_index = s.bit_index + 4'd1;
            s.pstep = PS_0;
            if (s.bit_index < 4'd8) r = bit_write(s, s.shift_byte[7], scl, av, tmo);
            else r = bit_read(s, scl, sda, av, tmo);
          end
        end else begin
          r = bit_read(s, scl, sda, av, tmo);
          if (r == RS_OK && s.sampled) r = RS_NACK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void enter(inout seq_t s, inout phase_t ph, input phase_t p,
                                input logic [7:0] b);
    ph = p;
    s.pstep = PS_0;
    s.bit_index = 4'd0;
    s.shift_byte = b;
  endfunction

  // Registers.
  logic [15:0]  half_bit_ticks;
  logic [23:0]  stretch_timeout_ticks;
  phase_t       phase, phase_next;
  seq_t         seq, seq_next;
  logic         burst_open, burst_open_next;
  logic         burst_is_read, burst_is_read_next;
  iepm_status_t err_code, err_code_next;
  held_t        held, held_next;
  iepm_result_t res_q, res_next;
  logic         res_valid;

  logic         in_take;
  logic         run;
  rs_t          r;
  logic [15:0]  arm_val;
  logic [7:0]   ctrl_w, ctrl_r;
  iepm_status_t fin_code;
  logic         fin;
  iepm_status_t fail_code;
  logic         fail_now;

  assign cmd.ready = !res_valid || res.ready;
  assign in_take   = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.data  = res_q;
  assign arm_val   = (half_bit_ticks == 16'd0) ? 16'd0 : half_bit_ticks - 16'd1;

  // Sequencer: one tick of work per accepted item.
  always_comb begin
    seq_next           = seq;
    phase_next         = phase;
    burst_open_next    = burst_open;
    burst_is_read_next = burst_is_read;
    err_code_next      = err_code;
    held_next          = held;
    run                = 1'b0;
    r                  = RS_BUSY;
    fin                = 1'b0;
    fin_code           = ST_OK;
    fail_now           = 1'b0;
    fail_code          = ST_OK;
    res_next           = '0;

    // Command intake while idle, otherwise the hold countdown.
    if (phase == PH_IDLE) begin
      if (cmd.data.cmd_valid) begin
        held_next.func = cmd.data.func;
        held_next.dev  = cmd.data.device_select;
        held_next.addr = cmd.data.address & ADDR_MASK;
        held_next.data = cmd.data.write_data;
        held_next.last = cmd.data.last_byte;
        seq_next.wait_cnt = '0;
        if (held_next.func) begin
          if (burst_open && burst_is_read) enter(seq_next, phase_next, PH_R_BYTE, 8'd0);
          else if (burst_open) enter(seq_next, phase_next, PH_PRESTOP, 8'd0);
          else enter(seq_next, phase_next, PH_R_START, 8'd0);
        end else begin
          if (burst_open && !burst_is_read && (held_next.addr % PAGE_BYTES) != 16'd0)
            enter(seq_next, phase_next, PH_W_DATA, held_next.data);
          else if (burst_open) enter(seq_next, phase_next, PH_PRESTOP, 8'd0);
          else enter(seq_next, phase_next, PH_W_START, 8'd0);
        end
        run = 1'b1;
      end
    end else if (seq.wait_cnt != 16'd0) begin
      seq_next.wait_cnt = seq.wait_cnt - 16'd1;
      run = (seq_next.wait_cnt == 16'd0);
    end else begin
      run = 1'b1;
    end

    ctrl_w = CTRL_WRITE | {4'd0, held_next.dev, 1'b0};
    ctrl_r = CTRL_READ | {4'd0, held_next.dev, 1'b0};

    if (run) begin
      r = run_step(seq_next, phase_next, ~held_next.last, cmd.data.scl_in,
                   cmd.data.sda_in, arm_val, stretch_timeout_ticks);
      if (r != RS_BUSY) begin
        // Phase transitions on completion.
        unique case (phase_next)
          PH_PRESTOP: begin
            if (r != RS_OK) begin fail_now = 1'b1; fail_code = ST_STOP; end
            else begin
              burst_open_next = 1'b0;
              enter(seq_next, phase_next, held_next.func ? PH_R_START : PH_W_START, 8'd0);
            end
          end
          PH_W_START: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_W_CTRL, ctrl_w);
            else enter(seq_next, phase_next, PH_W_START, 8'd0);
          end
          PH_W_CTRL: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_W_AHI, held_next.addr[15:8]);
            else enter(seq_next, phase_next, PH_W_START, 8'd0);
          end
          PH_W_AHI: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_W_ALO, held_next.addr[7:0]);
            else begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end
          end
          PH_W_ALO: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_W_DATA, held_next.data);
            else begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end
          end
          PH_W_DATA: begin
            if (r != RS_OK) begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end else begin
              burst_open_next = 1'b1; burst_is_read_next = 1'b0;
              if (held_next.last) enter(seq_next, phase_next, PH_W_STOP, 8'd0);
              else begin fin = 1'b1; fin_code = ST_OK; end
            end
          end
          PH_R_START: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_CTRLW, ctrl_w);
            else enter(seq_next, phase_next, PH_R_START, 8'd0);
          end
          PH_R_CTRLW: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_AHI, held_next.addr[15:8]);
            else enter(seq_next, phase_next, PH_R_START, 8'd0);
          end
          PH_R_AHI: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_ALO, held_next.addr[7:0]);
            else begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end
          end
          PH_R_ALO: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_RESTART, 8'd0);
            else begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end
          end
          PH_R_RESTART: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_CTRLR, ctrl_r);
            else begin fail_now = 1'b1; fail_code = ST_BUSY; end
          end
          PH_R_CTRLR: begin
            if (r == RS_OK) enter(seq_next, phase_next, PH_R_BYTE, 8'd0);
            else begin
              fail_now = 1'b1; fail_code = (r == RS_TIMEOUT) ? ST_TIMEOUT : ST_NACK;
            end
          end
          PH_R_BYTE: begin
            if (r != RS_OK) begin fail_now = 1'b1; fail_code = ST_TIMEOUT; end
            else begin
              burst_open_next = 1'b1; burst_is_read_next = 1'b1;
              if (held_next.last)
                enter(seq_next, phase_next, PH_R_STOP, seq_next.shift_byte);
              else begin fin = 1'b1; fin_code = ST_OK; end
            end
          end
          PH_W_STOP, PH_R_STOP: begin
            burst_open_next = 1'b0; burst_is_read_next = 1'b0;
            if (r == RS_OK) begin fin = 1'b1; fin_code = ST_OK; end
            else begin fail_now = 1'b1; fail_code = ST_STOP; end
          end
          PH_ERR_STOP: begin
            fin = 1'b1; fin_code = err_code_next;
          end
          default: enter(seq_next, phase_next, PH_IDLE, 8'd0);
        endcase

        // Command end, or an error that closes the burst with a stop.
        if (fin) begin
          res_next.done_res = 1'b1;
          res_next.status   = fin_code;
          res_next.read_data = (fin_code == ST_OK && held_next.func) ?
                               seq_next.shift_byte : 8'd0;
          enter(seq_next, phase_next, PH_IDLE, 8'd0);
        end
        if (fail_now) begin
          err_code_next      = fail_code;
          burst_open_next    = 1'b0;
          burst_is_read_next = 1'b0;
          enter(seq_next, phase_next, PH_ERR_STOP, 8'd0);
        end

        // First action of the phase just entered.
        if (phase_next != PH_IDLE)
          void'(run_step(seq_next, phase_next, ~held_next.last, cmd.data.scl_in,
                         cmd.data.sda_in, arm_val, stretch_timeout_ticks));
      end
    end

    res_next.scl_pull_low = seq_next.scl_drv;
    res_next.sda_pull_low = seq_next.sda_drv;
    res_next.ready_res    = (phase_next == PH_IDLE);
  end

  // Sequencer state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_IDLE;
      seq                   <= '0;
      burst_open            <= 1'b0;
      burst_is_read         <= 1'b0;
      err_code              <= ST_OK;
      held                  <= '0;
      half_bit_ticks        <= 16'd5;
      stretch_timeout_ticks <= 24'd1000;
    end else begin
      if (in_take) begin
        phase         <= phase_next;
        seq           <= seq_next;
        burst_open    <= burst_open_next;
        burst_is_read <= burst_is_read_next;
        err_code      <= err_code_next;
        held          <= held_next;
      end
      if (cfg.valid) begin
        unique case (cfg.data.reg_index)
          CFG_HALF_BIT: half_bit_ticks        <= cfg.data.wdata[15:0];
          CFG_STRETCH:  stretch_timeout_ticks <= cfg.data.wdata;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_q <= res_next;
    end
  end

endmodule

### rtl/core/iepm_checker.sv
// Port-level checks for the I2C EEPROM page master, bound to its top level.
// Depends on iepm_pkg and i2c_eeprom_page_master_top.
module iepm_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input iepm_pkg::iepm_result_t res_data
);
  import iepm_pkg::*;

  // A stalled result item holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result item changed while stalled");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

  // A non-zero status only comes with a finished command.
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |-> res_data.done_res)
    else $error("status without done");

  // A finished command leaves the sequencer ready for the next one.
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> res_data.ready_res)
    else $error("done without ready");

endmodule

bind i2c_eeprom_page_master_top iepm_checker u_iepm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
